// ===== rtl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and codes for the depth-first search engine.
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int FUNC_W   = 2;
  localparam int NODE_W   = 6;
  localparam int VCNT_W   = 5;
  localparam int VERTEX_W = 5;
  localparam int STATUS_W = 3;

  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 2'd0,
    FN_ADD    = 2'd1,
    FN_SEARCH = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_VISIT = 3'd0,
    RS_OK    = 3'd1,
    RS_BAD   = 3'd2,
    RS_FULL  = 3'd3
  } res_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADD,
    ST_READ,
    ST_EVAL,
    ST_POP,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic        latch_in;
    logic        clear_deg;
    logic        add_write;
    logic        search_init;
    logic        step;
    logic        push;
    logic        pop;
    logic        pop_load;
    logic        out_load;
    logic        out_pending;
    logic        out_last;
    res_status_t out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t func;
    logic  a_ok;
    logic  b_ok;
    logic  deg_full;
    logic  edges_done;
    logic  w_new;
    logic  depth_one;
    logic  out_free;
  } sts_t;

endpackage

// ===== rtl/dfs_ram.sv =====
// ----------------------------------------------------------------------------
// dfs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfs_ctrl
// Sequencer for edge updates and the stack-based depth-first walk.
// ----------------------------------------------------------------------------
module dfs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dfs_pkg::sts_t sts,
  output dfs_pkg::cmd_t cmd
);

  dfs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dfs_pkg::ST_IDLE: begin
        if (in_valid) state_next = dfs_pkg::ST_CHECK;
      end
      dfs_pkg::ST_CHECK: begin
        case (sts.func)
          dfs_pkg::FN_CLEAR: begin
            if (sts.out_free) state_next = dfs_pkg::ST_IDLE;
          end
          dfs_pkg::FN_ADD: begin
            if (sts.a_ok && sts.b_ok) state_next = dfs_pkg::ST_ADD;
            else if (sts.out_free) state_next = dfs_pkg::ST_IDLE;
          end
          dfs_pkg::FN_SEARCH: begin
            if (sts.a_ok) state_next = dfs_pkg::ST_READ;
            else if (sts.out_free) state_next = dfs_pkg::ST_IDLE;
          end
          default: state_next = dfs_pkg::ST_IDLE;
        endcase
      end
      dfs_pkg::ST_ADD: begin
        if (sts.out_free) state_next = dfs_pkg::ST_IDLE;
      end
      dfs_pkg::ST_READ: state_next = dfs_pkg::ST_EVAL;
      dfs_pkg::ST_EVAL: begin
        if (sts.edges_done) begin
          state_next = sts.depth_one ? dfs_pkg::ST_FINISH : dfs_pkg::ST_POP;
        end else if (!sts.w_new || sts.out_free) begin
          state_next = dfs_pkg::ST_READ;
        end
      end
      dfs_pkg::ST_POP: state_next = dfs_pkg::ST_READ;
      dfs_pkg::ST_FINISH: begin
        if (sts.out_free) state_next = dfs_pkg::ST_IDLE;
      end
      default: state_next = dfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_status = dfs_pkg::RS_VISIT;
    in_ready = 1'b0;
    case (state)
      dfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.latch_in = in_valid;
      end
      dfs_pkg::ST_CHECK: begin
        case (sts.func)
          dfs_pkg::FN_CLEAR: begin
            if (sts.out_free) begin
              cmd.clear_deg  = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = dfs_pkg::RS_OK;
            end
          end
          dfs_pkg::FN_ADD: begin
            if (!(sts.a_ok && sts.b_ok) && sts.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = dfs_pkg::RS_BAD;
            end
          end
          dfs_pkg::FN_SEARCH: begin
            if (sts.a_ok) begin
              cmd.search_init = 1'b1;
            end else if (sts.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = dfs_pkg::RS_BAD;
            end
          end
          default: ;
        endcase
      end
      dfs_pkg::ST_ADD: begin
        if (sts.out_free) begin
          cmd.add_write  = !sts.deg_full;
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = sts.deg_full ? dfs_pkg::RS_FULL : dfs_pkg::RS_OK;
        end
      end
      dfs_pkg::ST_EVAL: begin
        if (sts.edges_done) begin
          cmd.pop = !sts.depth_one;
        end else if (sts.w_new) begin
          if (sts.out_free) begin
            cmd.push        = 1'b1;
            cmd.out_load    = 1'b1;
            cmd.out_pending = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      dfs_pkg::ST_POP: cmd.pop_load = 1'b1;
      dfs_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_pending = 1'b1;
          cmd.out_last    = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/dfs_datapath.sv =====
// ----------------------------------------------------------------------------
// dfs_datapath
// Edge and degree memories, walk stack, visited marks and result register.
// ----------------------------------------------------------------------------
module dfs_datapath #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [dfs_pkg::VCNT_W-1:0]     cfg_wdata,
  input  logic [dfs_pkg::FUNC_W-1:0]     in_func,
  input  logic [dfs_pkg::NODE_W-1:0]     in_node_a,
  input  logic [dfs_pkg::NODE_W-1:0]     in_node_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dfs_pkg::VERTEX_W-1:0]   out_vertex,
  output logic [dfs_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_last,
  input  dfs_pkg::cmd_t                  cmd,
  output dfs_pkg::sts_t                  sts
);

  localparam int VW  = $clog2(MAX_VERTICES + 1);
  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int EAW = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam int DPW = $clog2(MAX_VERTICES + 1);
  localparam int SW  = VW + DW;

  logic [dfs_pkg::VCNT_W-1:0] vertex_count;
  logic [dfs_pkg::NODE_W-1:0] active;
  logic [dfs_pkg::FUNC_W-1:0] func_q;
  logic [dfs_pkg::NODE_W-1:0] a_q, b_q;
  logic                       mode_search;
  logic [MAX_VERTICES-1:0]    deg_valid;
  logic [MAX_VERTICES-1:0]    visited;
  logic [VW-1:0]              cur_v, pending;
  logic [DW-1:0]              cur_i;
  logic [DPW-1:0]             depth;

  logic [VIW-1:0] a_idx, cur_idx, deg_idx, w_idx;
  logic [DW-1:0]  deg_rdata, deg_val;
  logic [VW-1:0]  w;
  logic [SW-1:0]  stk_rdata;
  logic [EAW-1:0] edge_waddr, edge_raddr;

  assign active = ({1'b0, vertex_count} > dfs_pkg::NODE_W'(MAX_VERTICES))
                  ? dfs_pkg::NODE_W'(MAX_VERTICES) : {1'b0, vertex_count};

  assign a_idx   = VIW'(a_q - 1'b1);
  assign cur_idx = VIW'(cur_v - 1'b1);
  assign deg_idx = mode_search ? cur_idx : a_idx;
  assign deg_val = deg_valid[deg_idx] ? deg_rdata : '0;
  assign w_idx   = VIW'(w - 1'b1);

  assign edge_raddr = EAW'(cur_idx) * EAW'(MAX_DEGREE) + EAW'(cur_i);
  assign edge_waddr = EAW'(a_idx) * EAW'(MAX_DEGREE) + EAW'(deg_val);

  dfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_edge_ram (
    .clk   (clk),
    .we    (cmd.add_write),
    .waddr (edge_waddr),
    .wdata (VW'(b_q)),
    .raddr (edge_raddr),
    .rdata (w)
  );

  dfs_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg_ram (
    .clk   (clk),
    .we    (cmd.add_write),
    .waddr (a_idx),
    .wdata (deg_val + 1'b1),
    .raddr (deg_idx),
    .rdata (deg_rdata)
  );

  dfs_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (VIW'(depth - 1'b1)),
    .wdata ({cur_v, cur_i + 1'b1}),
    .raddr (VIW'(depth - 2'd2)),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= dfs_pkg::VCNT_RESET;
      deg_valid    <= '0;
      mode_search  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wen) vertex_count <= cfg_wdata;
      if (cmd.clear_deg) deg_valid <= '0;
      else if (cmd.add_write) deg_valid[a_idx] <= 1'b1;
      if (cmd.latch_in) mode_search <= 1'b0;
      else if (cmd.search_init) mode_search <= 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_q <= in_func;
      a_q    <= in_node_a;
      b_q    <= in_node_b;
    end
    if (cmd.search_init) begin
      visited <= MAX_VERTICES'(1) << a_idx;
      cur_v   <= VW'(a_q);
      cur_i   <= '0;
      depth   <= DPW'(1);
      pending <= VW'(a_q);
    end else if (cmd.push) begin
      visited[w_idx] <= 1'b1;
      cur_v          <= w;
      cur_i          <= '0;
      depth          <= depth + 1'b1;
      pending        <= w;
    end else if (cmd.step) begin
      cur_i <= cur_i + 1'b1;
    end else if (cmd.pop) begin
      depth <= depth - 1'b1;
    end else if (cmd.pop_load) begin
      cur_v <= stk_rdata[SW-1:DW];
      cur_i <= stk_rdata[DW-1:0];
    end
    if (cmd.out_load) begin
      out_vertex <= cmd.out_pending ? dfs_pkg::VERTEX_W'(pending) : '0;
      out_status <= cmd.out_status;
      out_last   <= cmd.out_last;
    end
  end

  always_comb begin
    sts.func       = dfs_pkg::func_t'(func_q);
    sts.a_ok       = (a_q != '0) && (a_q <= active);
    sts.b_ok       = (b_q != '0) && (b_q <= active);
    sts.deg_full   = deg_val >= DW'(MAX_DEGREE);
    sts.edges_done = cur_i >= deg_val;
    sts.w_new      = (w != '0) && (dfs_pkg::NODE_W'(w) <= active) && !visited[w_idx];
    sts.depth_one  = depth == DPW'(1);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== rtl/depth_first_search_engine.sv =====
// ----------------------------------------------------------------------------
// depth_first_search_engine
// Directed graph built edge by edge, answering depth-first walks.
// ----------------------------------------------------------------------------
// clear and add-edge: result loaded in CHECK, or in ADD for a well-formed add
// search: READ and EVAL per scanned edge, EVAL, POP and READ per backtrack,
//   set by the registered reads of the edge, degree and stack memories
// one transaction in flight; the next is taken once the last result is queued
// reset: control, degree valid bits and vertex_count (16) are restored;
//   edge and stack memories are not cleared
// ----------------------------------------------------------------------------
module depth_first_search_engine #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // node_a, node_b, zero pad
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // vertex, zero pad
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast
);

  dfs_pkg::cmd_t cmd;
  dfs_pkg::sts_t sts;
  logic [dfs_pkg::VERTEX_W-1:0] vertex;

  dfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfs_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_func    (s_tuser),
    .in_node_a  (s_tdata[5:0]),
    .in_node_b  (s_tdata[11:6]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_vertex (vertex),
    .out_status (m_tuser),
    .out_last   (m_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign m_tdata = {3'b000, vertex};

endmodule

// ===== rtl/dfs_checker.sv =====
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks for the depth-first search engine.
// ----------------------------------------------------------------------------
module dfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // one transaction at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // visits carry a real vertex
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == dfs_pkg::RS_VISIT |-> m_tdata != 8'd0)
    else $error("visit with vertex zero");

  // non-visit results are single, final and carry no vertex
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != dfs_pkg::RS_VISIT |-> m_tdata == 8'd0 && m_tlast)
    else $error("bad non-visit result");

  // only defined status codes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == dfs_pkg::RS_VISIT || m_tuser == dfs_pkg::RS_OK
      || m_tuser == dfs_pkg::RS_BAD || m_tuser == dfs_pkg::RS_FULL)
    else $error("undefined status code");

endmodule

bind depth_first_search_engine dfs_checker u_dfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
